/* rtl/core/qpx_pkg.sv */
// Package for the query parameter extractor: parse and escape phase types,
// character constants, the per-word step state and result types, helpers.
// No dependencies.
package qpx_pkg;

  // Characters that steer the parser.
  localparam logic [7:0] CHAR_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CHAR_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHAR_QUERY = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

  // Configuration register indices.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LEN  = 2'd2;

  // Where the parser stands within the query string.
  typedef enum logic [3:0] {
    PH_MATCH = 4'b0001,  // comparing the key of the current pair
    PH_SKIP  = 4'b0010,  // skipping to the next '&'
    PH_VALUE = 4'b0100,  // inside the value of the matched pair
    PH_IDLE  = 4'b1000   // value finished, waiting for the end
  } phase_e;

  // Progress through a percent escape.
  typedef enum logic [3:0] {
    ESC_NONE   = 4'b0001,
    ESC_FIRST  = 4'b0010,  // '%' seen
    ESC_SECOND = 4'b0100,  // first hex digit seen
    ESC_DROP   = 4'b1000   // drop one more byte
  } esc_e;

  // Parse state carried from word to word (key position kept apart).
  typedef struct packed {
    phase_e     phase;
    esc_e       esc;
    logic [3:0] digit;
    logic       found;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase: PH_MATCH, esc: ESC_NONE, digit: 4'h0, found: 1'b0
  };

  // One result word.
  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    logic       done_res;
    logic       key_found;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] data;
  } flush_t;

  // Value of an ASCII hex digit, with a flag for a valid digit.
  function automatic hex_t hex_decode(logic [7:0] b);
    hex_t r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r.ok  = 1'b1;
      r.val = 4'(b - 8'h37);
    end
    return r;
  endfunction

  // Byte that a pending escape gives when it is cut short.
  function automatic flush_t esc_flush(esc_e esc, logic [3:0] digit);
    flush_t r;
    r = '0;
    unique case (esc)
      ESC_FIRST: begin
        r.emit = 1'b1;
        r.data = CHAR_QUERY;
      end
      ESC_SECOND: begin
        r.emit = 1'b1;
        r.data = {4'h0, digit};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/qpx_step.sv */
// Next-state and result logic for one query word of the extractor.
// Purely combinational; uses qpx_pkg.
module qpx_step import qpx_pkg::*; #(
  parameter int unsigned MaxKeyLength = 16,
  parameter int unsigned KeyPosW      = $clog2(MaxKeyLength + 1)
) (
  input  logic [7:0]         query_byte_i,
  input  logic               end_of_query_i,
  input  logic [63:0]        key_low_i,
  input  logic [63:0]        key_high_i,
  input  logic [4:0]         key_length_i,
  input  parse_state_t       state_i,
  input  logic [KeyPosW-1:0] key_pos_i,
  output parse_state_t       state_o,
  output logic [KeyPosW-1:0] key_pos_o,
  output logic               has_result_o,
  output result_t            result_o
);

  localparam logic [4:0] MaxLen = 5'(MaxKeyLength);

  logic [4:0]         len_clip;
  logic [KeyPosW-1:0] eff_len;
  logic [127:0]       key_all;
  logic [3:0]         key_idx;
  logic [7:0]         key_ch;
  hex_t               hx;
  flush_t             fl_amp;
  flush_t             fl_end;
  parse_state_t       nxt;
  logic [KeyPosW-1:0] nkp;
  logic               emit;
  logic [7:0]         ob;

  // Effective key length: zero acts as one, long values clip to the maximum.
  always_comb begin
    if (key_length_i == 5'd0) begin
      len_clip = 5'd1;
    end else if (key_length_i > MaxLen) begin
      len_clip = MaxLen;
    end else begin
      len_clip = key_length_i;
    end
  end
  assign eff_len = KeyPosW'(len_clip);

  // Expected key character at the current position.
  assign key_all = {key_high_i, key_low_i};
  assign key_idx = 4'(key_pos_i);
  assign key_ch  = key_all[{key_idx, 3'b000} +: 8];

  assign hx     = hex_decode(query_byte_i);
  assign fl_amp = esc_flush(state_i.esc, state_i.digit);

  // Main parse step.
  always_comb begin
    nxt  = state_i;
    nkp  = key_pos_i;
    emit = 1'b0;
    ob   = 8'h00;
    unique case (state_i.phase)
      PH_MATCH: begin
        if (key_pos_i < eff_len) begin
          if (query_byte_i == key_ch) begin
            nkp = key_pos_i + KeyPosW'(1);
          end else if (query_byte_i == CHAR_AMP) begin
            nkp = '0;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end else if (query_byte_i == CHAR_EQ) begin
          nxt.phase = PH_VALUE;
          nxt.found = 1'b1;
          nxt.esc   = ESC_NONE;
        end else if (query_byte_i == CHAR_AMP) begin
          nkp = '0;
        end else begin
          nxt.phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (query_byte_i == CHAR_AMP) begin
          nxt.phase = PH_MATCH;
          nkp       = '0;
        end
      end
      PH_VALUE: begin
        if (query_byte_i == CHAR_AMP) begin
          emit      = fl_amp.emit;
          ob        = fl_amp.data;
          nxt.esc   = ESC_NONE;
          nxt.phase = PH_IDLE;
        end else begin
          unique case (state_i.esc)
            ESC_FIRST: begin
              if (hx.ok) begin
                nxt.digit = hx.val;
                nxt.esc   = ESC_SECOND;
              end else begin
                ob      = CHAR_QUERY;
                emit    = 1'b1;
                nxt.esc = ESC_DROP;
              end
            end
            ESC_SECOND: begin
              ob      = hx.ok ? {state_i.digit, hx.val} : {4'h0, state_i.digit};
              emit    = 1'b1;
              nxt.esc = ESC_NONE;
            end
            ESC_DROP: begin
              nxt.esc = ESC_NONE;
            end
            default: begin
              if (query_byte_i == CHAR_PCT) begin
                nxt.esc = ESC_FIRST;
              end else begin
                ob   = (query_byte_i == CHAR_PLUS) ? CHAR_SPACE : query_byte_i;
                emit = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  // An escape still pending at the last word of the query is flushed.
  assign fl_end = esc_flush(nxt.esc, nxt.digit);

  always_comb begin
    state_o          = nxt;
    key_pos_o        = nkp;
    result_o.value_byte  = ob;
    result_o.value_valid = emit;
    if (end_of_query_i && !emit && nxt.phase == PH_VALUE) begin
      result_o.value_valid = fl_end.emit;
      result_o.value_byte  = fl_end.data;
    end
    if (!result_o.value_valid) begin
      result_o.value_byte = 8'h00;
    end
    result_o.done_res  = end_of_query_i;
    result_o.key_found = end_of_query_i & nxt.found;
    has_result_o       = result_o.value_valid | end_of_query_i;
    // The end of the query returns all parse state to its reset value.
    if (end_of_query_i) begin
      state_o   = PARSE_RESET;
      key_pos_o = '0;
    end
  end

endmodule

/* rtl/core/query_param_extract_decode_top.sv */
// Query parameter extractor with URL decoding; uses qpx_pkg and qpx_step.
// A query word is registered in the input stage on acceptance, and its result
// word is registered in the result register as it leaves that stage. Throughput: one query word per cycle while
// the result side keeps up; words that give no result never stall.
// Reset (rst_ni, asynchronous, active low) clears the parse state and the
// stages, and sets the key to zero with a key length of one.
module query_param_extract_decode_top import qpx_pkg::*; #(
  parameter int unsigned MaxKeyLength = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  // Query byte channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         query_byte_i,
  input  logic               end_of_query_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         value_byte_o,
  output logic               value_valid_o,
  output logic               done_res_o,
  output logic               key_found_o
);

  localparam int unsigned KeyPosW = $clog2(MaxKeyLength + 1);

  logic [63:0]        key_low_q;
  logic [63:0]        key_high_q;
  logic [4:0]         key_len_q;

  logic               s1_valid_q;
  logic [7:0]         s1_byte_q;
  logic               s1_last_q;

  parse_state_t       state_q;
  parse_state_t       state_d;
  logic [KeyPosW-1:0] key_pos_q;
  logic [KeyPosW-1:0] key_pos_d;

  logic               has_result;
  result_t            result_d;
  result_t            result_q;
  logic               out_valid_q;

  logic               out_free;
  logic               s1_advance;
  logic               in_fire;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= 5'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        CFG_KEY_LEN:  key_len_q  <= cfg_data_i[4:0];
        default:      key_len_q  <= key_len_q;
      endcase
    end
  end

  // Stage handshakes: the word in the input stage moves on unless it has a
  // result and the result register is still held.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && (!has_result || out_free);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= query_byte_i;
      s1_last_q <= end_of_query_i;
    end
  end

  // Parse step on the word held in the input stage.
  qpx_step #(
    .MaxKeyLength (MaxKeyLength),
    .KeyPosW      (KeyPosW)
  ) u_step (
    .query_byte_i   (s1_byte_q),
    .end_of_query_i (s1_last_q),
    .key_low_i      (key_low_q),
    .key_high_i     (key_high_q),
    .key_length_i   (key_len_q),
    .state_i        (state_q),
    .key_pos_i      (key_pos_q),
    .state_o        (state_d),
    .key_pos_o      (key_pos_d),
    .has_result_o   (has_result),
    .result_o       (result_d)
  );

  // Parse state moves only when the word leaves the input stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= PARSE_RESET;
      key_pos_q <= '0;
    end else if (s1_advance) begin
      state_q   <= state_d;
      key_pos_q <= key_pos_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_advance && has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance && has_result) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign value_byte_o  = result_q.value_byte;
  assign value_valid_o = result_q.value_valid;
  assign done_res_o    = result_q.done_res;
  assign key_found_o   = result_q.key_found;

endmodule
